// File: hdl/srs_pkg.sv
// Shared types, constants and sequence-number helpers for the selective-repeat sender.
package srs_pkg;

    localparam int SEQ_COUNT     = 8;
    localparam int WINDOW        = 4;
    localparam int PAYLOAD_WIDTH = 64;

    // Sequence number field width (fixed by the item format).
    localparam int SEQ_W = 3;

    localparam logic [SEQ_W:0]   SEQ_LIMIT = (SEQ_W + 1)'(SEQ_COUNT);
    localparam logic [SEQ_W:0]   WIN_LIMIT = (SEQ_W + 1)'(WINDOW);
    localparam logic [SEQ_W-1:0] SEQ_LAST  = SEQ_W'(SEQ_COUNT - 1);

    // Item kinds
    localparam logic [1:0] MODE_SEND    = 2'd0;
    localparam logic [1:0] MODE_ACK     = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [63:0]      payload;
        logic [SEQ_W-1:0] ack_number;
        logic             checksum_ok;
        logic [SEQ_W-1:0] timeout_number;
    } srs_in_t;

    typedef struct packed {
        logic             accepted;
        logic             tx_valid;
        logic [SEQ_W-1:0] tx_seq;
        logic [63:0]      tx_payload;
        logic             start_timer;
        logic             stop_timer;
        logic [SEQ_W-1:0] timer_seq;
        logic             window_full;
        logic [SEQ_W-1:0] base_number;
    } srs_out_t;

    // Commands from the sequencer to the window tracker
    typedef struct packed {
        logic             send;
        logic             mark;
        logic [SEQ_W-1:0] num;
    } srs_win_cmd_t;

    // Window tracker status
    typedef struct packed {
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] next;
        logic             blocked;
        logic             busy;
    } srs_win_stat_t;

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] a);
        logic [SEQ_W-1:0] r;
        if (a == SEQ_LAST) begin
            r = '0;
        end else begin
            r = a + 1'b1;
        end
        return r;
    endfunction

    // (a - b) modulo SEQ_COUNT
    function automatic logic [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] a,
                                                 input logic [SEQ_W-1:0] b);
        logic [SEQ_W:0] t;
        t = {1'b0, a} - {1'b0, b};
        if (a < b) begin
            t = t + SEQ_LIMIT;
        end
        return t[SEQ_W-1:0];
    endfunction

endpackage

// File: hdl/selective_repeat_sender_unit.sv
// Selective-repeat ARQ sender top level: sequencer, result register, store and window.
//
//  channel | signals                     | transfer when
//  --------+-----------------------------+------------------------
//  input   | in_valid, in_ready, in_data | in_valid && in_ready
//  output  | out_valid, out_ready,       | out_valid && out_ready
//          | out_data                    |
//
// One item at a time. A new message goes from S_IDLE straight to S_RESULT; a
// timeout passes through S_READ for the packet store read (registered read
// data); an ack passes through S_SLIDE and stays there while the base slide
// walker, which clears one mark per cycle, is busy.
// in_ready returns in the cycle after the result is loaded.
// The result sits in an output register; the next item is taken while it
// waits, and that item's result is held until the register is free.
// Reset clears the window state and the acked marks; the packet store has
// no reset and needs no clearing pass.
module selective_repeat_sender_unit
    import srs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  srs_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output srs_out_t out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SLIDE,
        S_RESULT
    } state_t;

    state_t   state_reg, state_next;
    srs_out_t res_reg, res_next;
    srs_out_t out_reg, out_next;
    logic     out_valid_reg, out_valid_next;

    srs_win_cmd_t             win_cmd;
    srs_win_stat_t            win_stat;
    logic                     ack_ok;
    logic                     accept;
    logic                     ack_hit;
    logic                     to_hit;
    logic                     rd_en;
    logic [PAYLOAD_WIDTH-1:0] rd_data;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Ack qualifies: good checksum, number in range, not yet acked, inside window
    assign ack_hit = in_data.checksum_ok
                  && ({1'b0, in_data.ack_number} < SEQ_LIMIT)
                  && ack_ok;
    assign to_hit  = ({1'b0, in_data.timeout_number} < SEQ_LIMIT);

    always_comb
    begin
        win_cmd.send = accept && (in_data.mode == MODE_SEND) && !win_stat.blocked;
        win_cmd.mark = accept && (in_data.mode == MODE_ACK) && ack_hit;
        win_cmd.num  = in_data.ack_number;
    end

    assign rd_en = accept && (in_data.mode == MODE_TIMEOUT);

    // Store write on send, read on timeout; only one item is in flight,
    // so a read never overlaps a write to the same entry.
    srs_store u_store (
        .clk     (clk),
        .wr_en   (win_cmd.send),
        .wr_addr (win_stat.next),
        .wr_data (in_data.payload[PAYLOAD_WIDTH-1:0]),
        .rd_en   (rd_en),
        .rd_addr (in_data.timeout_number),
        .rd_data (rd_data)
    );

    srs_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (win_cmd),
        .query  (in_data.ack_number),
        .ack_ok (ack_ok),
        .stat   (win_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    case (in_data.mode)
                        MODE_SEND:
                        begin
                            if (!win_stat.blocked)
                            begin
                                res_next.accepted    = 1'b1;
                                res_next.tx_valid    = 1'b1;
                                res_next.tx_seq      = win_stat.next;
                                res_next.tx_payload  = 64'(in_data.payload[PAYLOAD_WIDTH-1:0]);
                                res_next.start_timer = 1'b1;
                                res_next.timer_seq   = win_stat.next;
                            end
                            state_next = S_RESULT;
                        end
                        MODE_ACK:
                        begin
                            if (ack_hit)
                            begin
                                res_next.stop_timer = 1'b1;
                                res_next.timer_seq  = in_data.ack_number;
                            end
                            state_next = S_SLIDE;
                        end
                        MODE_TIMEOUT:
                        begin
                            if (to_hit)
                            begin
                                res_next.tx_valid    = 1'b1;
                                res_next.tx_seq      = in_data.timeout_number;
                                res_next.start_timer = 1'b1;
                                res_next.timer_seq   = in_data.timeout_number;
                            end
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (res_reg.tx_valid)
                begin
                    res_next.tx_payload = 64'(rd_data);
                end
                state_next = S_RESULT;
            end
            S_SLIDE:
            begin
                if (!win_stat.busy)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                // window state is final here; hold until the output register frees
                if (!out_valid_reg || out_ready)
                begin
                    out_next             = res_reg;
                    out_next.window_full = win_stat.blocked;
                    out_next.base_number = win_stat.base;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_accept_starts_timer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.accepted
        |-> out_reg.tx_valid && out_reg.start_timer && !out_reg.stop_timer)
        else $error("accepted message without send and timer start");

    a_one_timer_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.start_timer && out_reg.stop_timer))
        else $error("start and stop timer together");

    a_send_advances: assert property (@(posedge clk) disable iff (!rst_n)
        win_cmd.send |=> (win_stat.next == seq_inc($past(win_stat.next))))
        else $error("next number did not advance on send");

endmodule

// File: hdl/srs_store.sv
// Packet store: one write port, one read port, registered read data.
module srs_store
    import srs_pkg::*;
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [SEQ_W-1:0]         wr_addr,
    input  logic [PAYLOAD_WIDTH-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [SEQ_W-1:0]         rd_addr,
    output logic [PAYLOAD_WIDTH-1:0] rd_data
);

    logic [PAYLOAD_WIDTH-1:0] mem [SEQ_COUNT];
    logic [PAYLOAD_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/srs_window.sv
// Window tracker: ack marks, base, next number, full flag and the base slide walker.
module srs_window
    import srs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  srs_win_cmd_t     cmd,
    input  logic [SEQ_W-1:0] query,
    output logic             ack_ok,
    output srs_win_stat_t    stat
);

    logic [SEQ_COUNT-1:0] marks_reg, marks_next;
    logic [SEQ_W-1:0]     base_reg, base_next;
    logic [SEQ_W-1:0]     next_reg, next_next;
    logic                 blocked_reg, blocked_next;
    logic                 busy_reg, busy_next;
    logic [SEQ_W-1:0]     cnt_reg, cnt_next;

    always_comb
    begin
        marks_next   = marks_reg;
        base_next    = base_reg;
        next_next    = next_reg;
        blocked_next = blocked_reg;
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;

        if (cmd.send)
        begin
            marks_next[next_reg] = 1'b0;
            next_next            = seq_inc(next_reg);
            blocked_next = ({1'b0, seq_dist(seq_inc(next_reg), base_reg)} >= WIN_LIMIT);
        end

        if (cmd.mark)
        begin
            marks_next[cmd.num] = 1'b1;
            if (cmd.num == base_reg)
            begin
                // walk limit: numbers outstanding before the slide
                busy_next    = 1'b1;
                cnt_next     = seq_dist(next_reg, base_reg);
                blocked_next = 1'b0;
            end
        end

        // one mark per cycle
        if (busy_reg)
        begin
            if ((cnt_reg == '0) || !marks_reg[base_reg])
            begin
                busy_next = 1'b0;
            end else begin
                marks_next[base_reg] = 1'b0;
                base_next            = seq_inc(base_reg);
                cnt_next             = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg   <= '0;
            base_reg    <= '0;
            next_reg    <= '0;
            blocked_reg <= 1'b0;
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            marks_reg   <= marks_next;
            base_reg    <= base_next;
            next_reg    <= next_next;
            blocked_reg <= blocked_next;
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
        end
    end

    assign ack_ok = !marks_reg[query] && ({1'b0, seq_dist(query, base_reg)} < WIN_LIMIT);

    assign stat.base    = base_reg;
    assign stat.next    = next_reg;
    assign stat.blocked = blocked_reg;
    assign stat.busy    = busy_reg;

    a_no_send_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.send |-> !blocked_reg)
        else $error("send while window full");

    a_no_mark_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark |-> !busy_reg)
        else $error("ack mark during base slide");

    a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (cnt_reg != '0) && marks_reg[base_reg]
        |=> (base_reg == seq_inc($past(base_reg))) && !marks_reg[$past(base_reg)])
        else $error("base slide step lost");

endmodule

// File: dv/selective_repeat_sender_unit_tb.sv
// Self-checking testbench for the selective-repeat ARQ sender: directed table, then random traffic.
module selective_repeat_sender_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srs_pkg::*;

    // Item kind with no defined action; the block must leave its state alone.
    localparam logic [1:0] MODE_NOP = 2'd3;

    localparam int     RAND_ITEMS    = 1875;      // random items after the directed table
    localparam int     HOLD_AT       = 300;       // random item index where the long stall starts
    localparam int     LONG_HOLD     = 80;        // receiver stall, in cycles
    localparam int     CALM_FROM     = 900;       // stretch with no idling on either side
    localparam int     CALM_TO       = 1200;
    localparam int     DRAIN_CYCLES  = 16;        // > slowest item (ack with full slide, timeout)
    localparam longint LIMIT_NS      = 5_000_000;

    logic     clk      = 1'b0;
    logic     rst_n    = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    srs_in_t  in_data  = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    srs_out_t out_data;

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    selective_repeat_sender_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // Sender state as seen from outside: stored words, ack marks, window.
    // ------------------------------------------------------------------
    logic [63:0]      sent_words [SEQ_COUNT];
    bit               stored     [SEQ_COUNT];   // entry written at least once
    bit               acked      [SEQ_COUNT];
    logic [SEQ_W-1:0] base_q;
    logic [SEQ_W-1:0] next_q;
    bit               full_q;

    srs_out_t due_results [$];                  // expected output transfers, oldest first

    int mismatches = 0;
    int n_items    = 0;
    int n_checked  = 0;
    int n_refused  = 0;
    int n_stops    = 0;
    int n_resends  = 0;

    bit calm    = 1'b0;                         // no idling on either side while set
    bit hold_now = 1'b0;                        // ask the receiver for one long stall

    function automatic logic [SEQ_W-1:0] wrap_next(input logic [SEQ_W-1:0] n);
        return SEQ_W'((int'(n) + 1) % SEQ_COUNT);
    endfunction

    // Distance of n ahead of the window base, modulo the sequence space.
    function automatic int ahead_of_base(input logic [SEQ_W-1:0] n);
        return (int'(n) + SEQ_COUNT - int'(base_q)) % SEQ_COUNT;
    endfunction

    function automatic void arq_reset();
        foreach (acked[i])
        begin
            acked[i]      = 1'b0;
            stored[i]     = 1'b0;
            sent_words[i] = '0;
        end
        base_q = '0;
        next_q = '0;
        full_q = 1'b0;
    endfunction

    // One item in, one result out; updates the window state.
    function automatic srs_out_t arq_step(input srs_in_t it);
        srs_out_t r;
        int       span;
        r = '0;
        case (it.mode)
            MODE_SEND:
            begin
                if (!full_q)
                begin
                    acked[next_q]      = 1'b0;
                    sent_words[next_q] = it.payload;
                    stored[next_q]     = 1'b1;
                    r.accepted    = 1'b1;
                    r.tx_valid    = 1'b1;
                    r.tx_seq      = next_q;
                    r.tx_payload  = it.payload;
                    r.start_timer = 1'b1;
                    r.timer_seq   = next_q;
                    next_q = wrap_next(next_q);
                    if (ahead_of_base(next_q) >= WINDOW)
                        full_q = 1'b1;
                end
            end
            MODE_ACK:
            begin
                if (it.checksum_ok && !acked[it.ack_number] &&
                    ahead_of_base(it.ack_number) < WINDOW)
                begin
                    r.stop_timer = 1'b1;
                    r.timer_seq  = it.ack_number;
                    acked[it.ack_number] = 1'b1;
                    if (it.ack_number == base_q)
                    begin
                        // slide over the run of acked entries, only as far as next_q
                        span = ahead_of_base(next_q);
                        for (int k = 0; k < span; k++)
                        begin
                            if (!acked[base_q])
                                break;
                            acked[base_q] = 1'b0;
                            base_q = wrap_next(base_q);
                        end
                        full_q = 1'b0;
                    end
                end
            end
            MODE_TIMEOUT:
            begin
                // resend whatever sits in the store, outstanding or not
                r.tx_valid    = 1'b1;
                r.tx_seq      = it.timeout_number;
                r.tx_payload  = sent_words[it.timeout_number];
                r.start_timer = 1'b1;
                r.timer_seq   = it.timeout_number;
            end
            default:
            begin
            end
        endcase
        r.window_full = full_q;
        r.base_number = base_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    typedef struct {
        logic     typed;        // want holds a hand-written result
        srs_in_t  item;
        srs_out_t want;
    } plan_row_t;

    function automatic srs_in_t msg(input logic [63:0] word);
        srs_in_t it;
        it = '0;
        it.mode    = MODE_SEND;
        it.payload = word;
        return it;
    endfunction

    function automatic srs_in_t ack(input logic [SEQ_W-1:0] n, input logic ok);
        srs_in_t it;
        it = '0;
        it.mode        = MODE_ACK;
        it.ack_number  = n;
        it.checksum_ok = ok;
        return it;
    endfunction

    function automatic srs_in_t expiry(input logic [SEQ_W-1:0] n);
        srs_in_t it;
        it = '0;
        it.mode           = MODE_TIMEOUT;
        it.timeout_number = n;
        return it;
    endfunction

    function automatic srs_in_t nop(input logic fill);
        srs_in_t it;
        it = fill ? '1 : '0;
        it.mode = MODE_NOP;
        return it;
    endfunction

    function automatic srs_out_t outcome(input logic acc, input logic tx,
                                         input logic [SEQ_W-1:0] seq, input logic [63:0] pay,
                                         input logic start, input logic stop,
                                         input logic [SEQ_W-1:0] tseq, input logic full,
                                         input logic [SEQ_W-1:0] base);
        srs_out_t r;
        r.accepted    = acc;
        r.tx_valid    = tx;
        r.tx_seq      = seq;
        r.tx_payload  = pay;
        r.start_timer = start;
        r.stop_timer  = stop;
        r.timer_seq   = tseq;
        r.window_full = full;
        r.base_number = base;
        return r;
    endfunction

    function automatic plan_row_t row(input srs_in_t it);
        plan_row_t p;
        p.typed = 1'b0;
        p.item  = it;
        p.want  = '0;
        return p;
    endfunction

    function automatic plan_row_t row_want(input srs_in_t it, input srs_out_t w);
        plan_row_t p;
        p.typed = 1'b1;
        p.item  = it;
        p.want  = w;
        return p;
    endfunction

    // A number whose store entry holds a word; never ask for an unwritten one.
    function automatic logic [SEQ_W-1:0] any_stored();
        logic [SEQ_W-1:0] t;
        do
            t = SEQ_W'($urandom_range(0, SEQ_COUNT - 1));
        while (!stored[t]);
        return t;
    endfunction

    // Mostly protocol-shaped traffic (sends, acks and timeouts for outstanding
    // numbers), the rest bad checksums, stray acks, stray timeouts, nops.
    function automatic srs_in_t pick_item();
        srs_in_t it;
        int      roll;
        int      span;
        it.payload        = {$urandom, $urandom};
        it.ack_number     = SEQ_W'($urandom_range(0, SEQ_COUNT - 1));
        it.checksum_ok    = 1'($urandom_range(0, 1));
        it.timeout_number = SEQ_W'($urandom_range(0, SEQ_COUNT - 1));
        it.mode           = MODE_SEND;
        roll = $urandom_range(0, 99);
        span = ahead_of_base(next_q);
        if (roll < 38)
        begin
            it.mode = MODE_SEND;
        end
        else if (roll < 72)
        begin
            it.mode        = MODE_ACK;
            it.checksum_ok = ($urandom_range(0, 19) != 0);
            if (span > 0)
                it.ack_number = SEQ_W'((int'(base_q) + int'($urandom_range(0, span - 1)))
                                       % SEQ_COUNT);
        end
        else if (roll < 86)
        begin
            it.mode = MODE_TIMEOUT;
            if (span > 0)
                it.timeout_number = SEQ_W'((int'(base_q) + int'($urandom_range(0, span - 1)))
                                           % SEQ_COUNT);
            else
                it.timeout_number = any_stored();
        end
        else if (roll < 94)
        begin
            it.mode = MODE_ACK;
        end
        else if (roll < 97)
        begin
            it.mode = MODE_NOP;
        end
        else
        begin
            it.mode           = MODE_TIMEOUT;
            it.timeout_number = any_stored();
        end
        return it;
    endfunction

    // Present one item from a falling edge on, hold it until the input transfer,
    // then log its expected result. Returns at the rising edge of the transfer.
    task automatic offer(input srs_in_t it, input logic typed, input srs_out_t want,
                         output srs_out_t got);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        got = arq_step(it);
        due_results.push_back(typed ? want : got);
        n_items++;
        if (it.mode == MODE_SEND && !got.accepted)
            n_refused++;
        if (got.stop_timer)
            n_stops++;
        if (got.tx_valid && !got.accepted)
            n_resends++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long stall on request so the
    // result register and the held result both fill and in_ready drops.
    // ------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_now)
            begin
                hold_now = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                out_ready <= calm || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: every output transfer against the oldest expectation.
    // ------------------------------------------------------------------
    function automatic void check_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $display("[%0t] %s mismatch: expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        srs_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
            begin
                $display("[%0t] unexpected transfer: expected none, actual %h", $time, out_data);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("accepted",    64'(want.accepted),    64'(out_data.accepted));
                check_field("tx_valid",    64'(want.tx_valid),    64'(out_data.tx_valid));
                check_field("tx_seq",      64'(want.tx_seq),      64'(out_data.tx_seq));
                check_field("tx_payload",  want.tx_payload,       out_data.tx_payload);
                check_field("start_timer", 64'(want.start_timer), 64'(out_data.start_timer));
                check_field("stop_timer",  64'(want.stop_timer),  64'(out_data.stop_timer));
                check_field("timer_seq",   64'(want.timer_seq),   64'(out_data.timer_seq));
                check_field("window_full", 64'(want.window_full), 64'(out_data.window_full));
                check_field("base_number", 64'(want.base_number), 64'(out_data.base_number));
                n_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        plan_row_t plan [$];
        srs_out_t  got;
        srs_in_t   it;
        int        rand_sent;

        // Directed table. Typed results only where they are obvious.
        plan.push_back(row_want(nop(1'b0), outcome(0, 0, 0, '0, 0, 0, 0, 0, 0)));  // nop after reset
        plan.push_back(row_want(msg('1), outcome(1, 1, 0, '1, 1, 0, 0, 0, 0)));
        plan.push_back(row_want(msg('0), outcome(1, 1, 1, '0, 1, 0, 1, 0, 0)));
        plan.push_back(row(msg(64'h5555_5555_5555_5555)));
        plan.push_back(row_want(msg(64'hAAAA_AAAA_AAAA_AAAA),                      // window fills
                                outcome(1, 1, 3, 64'hAAAA_AAAA_AAAA_AAAA, 1, 0, 3, 1, 0)));
        plan.push_back(row_want(msg(64'h1234_5678_9ABC_DEF0),                      // refused
                                outcome(0, 0, 0, '0, 0, 0, 0, 1, 0)));
        plan.push_back(row_want(ack(1, 1'b0), outcome(0, 0, 0, '0, 0, 0, 0, 1, 0)));  // bad checksum
        plan.push_back(row(ack(5, 1'b1)));          // outside the window
        plan.push_back(row(ack(2, 1'b1)));          // out-of-order ack, no slide
        plan.push_back(row(ack(2, 1'b1)));          // already acked
        plan.push_back(row(expiry(3)));
        plan.push_back(row(expiry(0)));
        plan.push_back(row(ack(0, 1'b1)));          // base slides by one, window opens
        plan.push_back(row(ack(1, 1'b1)));          // slides over 1 and the acked 2
        plan.push_back(row(expiry(1)));             // resend of a number no longer outstanding
        plan.push_back(row(msg(64'h0123_4567_89AB_CDEF)));
        plan.push_back(row(ack(7, 1'b1)));          // just past the window edge
        plan.push_back(row(ack(6, 1'b1)));          // inside window, not yet sent
        plan.push_back(row(ack(3, 1'b1)));
        plan.push_back(row(ack(4, 1'b1)));          // slide stops at next number
        plan.push_back(row(msg(64'h8000_0000_0000_0001)));
        plan.push_back(row(msg(64'h7FFF_FFFF_FFFF_FFFE)));   // clears the early mark on 6
        plan.push_back(row(msg(64'hFFFF_0000_FFFF_0000)));
        plan.push_back(row(msg(64'h0000_FFFF_0000_FFFF)));   // sequence wraps, window full
        plan.push_back(row(nop(1'b1)));             // nop with every field bit set

        arq_reset();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            offer(plan[i].item, plan[i].typed, plan[i].want, got);

        // Random part, every item checked against the predictor.
        rand_sent = 0;
        while (rand_sent < RAND_ITEMS)
        begin
            if (rand_sent == HOLD_AT)
                hold_now = 1'b1;
            calm = (rand_sent >= CALM_FROM && rand_sent < CALM_TO);
            it = pick_item();
            offer(it, 1'b0, '0, got);
            rand_sent++;
        end
        calm = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input transfers and %0d checked results:", n_items, n_checked);
        $display("  %0d sends refused on a full window, %0d timers stopped, %0d resends.",
                 n_refused, n_stops, n_resends);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #LIMIT_NS;
        $display("Run timed out with %0d results still due.", due_results.size());
        $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hdl/srs_pkg.sv
hdl/srs_store.sv
hdl/srs_window.sv
hdl/selective_repeat_sender_unit.sv
dv/selective_repeat_sender_unit_tb.sv
